FILE: rtl/core/kpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants for the keypad debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int NUM_ROWS   = 4;
  localparam int ROW_W      = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int KEY_W      = 8;
  localparam int ROW_USED_W = 3;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCAN  = 2'd0,
    CMD_SHORT = 2'd1,
    CMD_LONG  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPEAT_KEYS  = 2'd0,
    CFG_FIRST_DELAY  = 2'd1,
    CFG_REPEAT_PER   = 2'd2
  } cfg_idx_t;

  localparam logic [KEY_W-1:0] RST_REPEAT_KEYS = 8'd255;
  localparam logic [KEY_W-1:0] RST_FIRST_DELAY = 8'd50;
  localparam logic [KEY_W-1:0] RST_REPEAT_PER  = 8'd20;

  typedef struct packed {
    logic [KEY_W-1:0] repeat_keys;
    logic [KEY_W-1:0] first_delay;
    logic [KEY_W-1:0] repeat_per;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0] debounced;
    logic [KEY_W-1:0] cnt_lo;
    logic [KEY_W-1:0] cnt_hi;
    logic [KEY_W-1:0] timer;
    logic [KEY_W-1:0] press;
    logic [KEY_W-1:0] rpt;
  } row_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/kpd_row_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_row_update
// Next state and answer for one row: vertical-counter debounce, press and
// repeat flags, repeat timer, short and long queries.
// ----------------------------------------------------------------------------
module kpd_row_update (
  input  wire logic [kpd_pkg::CMD_W-1:0] cmd,
  input  wire logic [kpd_pkg::KEY_W-1:0] raw_keys,
  input  wire logic [kpd_pkg::KEY_W-1:0] query_mask,
  input  wire kpd_pkg::cfg_t             cfg,
  input  wire kpd_pkg::row_state_t       cur,
  output kpd_pkg::row_state_t            nxt,
  output logic [kpd_pkg::KEY_W-1:0]      key_bits,
  output logic                           is_scan
);

  logic [kpd_pkg::KEY_W-1:0] diff;
  logic [kpd_pkg::KEY_W-1:0] lo_n;
  logic [kpd_pkg::KEY_W-1:0] hi_n;
  logic [kpd_pkg::KEY_W-1:0] toggle;
  logic [kpd_pkg::KEY_W-1:0] deb_n;
  logic [kpd_pkg::KEY_W-1:0] held;
  logic [kpd_pkg::KEY_W-1:0] tmr_a;
  logic [kpd_pkg::KEY_W-1:0] tmr_d;
  logic [kpd_pkg::KEY_W-1:0] got;

  assign diff   = cur.debounced ^ raw_keys;
  assign lo_n   = ~(cur.cnt_lo & diff);
  assign hi_n   = lo_n ^ (cur.cnt_hi & diff);
  assign toggle = diff & lo_n & hi_n;
  assign deb_n  = cur.debounced ^ toggle;
  assign held   = deb_n & cfg.repeat_keys;
  assign tmr_a  = (held == '0) ? cfg.first_delay : cur.timer;
  assign tmr_d  = tmr_a - 8'd1;
  assign got    = cur.rpt & query_mask;

  always_comb begin
    nxt      = cur;
    key_bits = '0;
    is_scan  = 1'b0;
    case (kpd_pkg::cmd_t'(cmd))
      kpd_pkg::CMD_SCAN: begin
        is_scan       = 1'b1;
        nxt.cnt_lo    = lo_n;
        nxt.cnt_hi    = hi_n;
        nxt.debounced = deb_n;
        nxt.press     = cur.press | (deb_n & toggle);
        if (tmr_d == '0) begin
          nxt.timer = cfg.repeat_per;
          nxt.rpt   = cur.rpt | held;
        end else begin
          nxt.timer = tmr_d;
        end
        key_bits = deb_n;
      end
      kpd_pkg::CMD_SHORT: begin
        key_bits = cur.press & ~cur.debounced & query_mask;
      end
      kpd_pkg::CMD_LONG: begin
        nxt.rpt  = cur.rpt ^ got;
        key_bits = cur.press & got;
      end
      default: begin
        key_bits = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/keypad_debounce_repeat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_debounce_repeat
// Multi-row 8-key debouncer with press latching and auto-repeat.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while out_stall does not hold a full pipe;
// input register, one pass of row logic on the current row's state
// registers, result register.
// Reset: synchronous, clears all row state, the row index and the valid flags
// of both stages; the repeat registers return to 255, 50 and 20.
module keypad_debounce_repeat (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [kpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [kpd_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [kpd_pkg::KEY_W-1:0]       in_raw_keys,
  input  wire logic [kpd_pkg::KEY_W-1:0]       in_query_mask,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [kpd_pkg::KEY_W-1:0]            out_key_bits,
  output logic [kpd_pkg::ROW_USED_W-1:0]       out_row_used
);

  kpd_pkg::cfg_t                 cfg_r;
  kpd_pkg::row_state_t           rows_r [kpd_pkg::NUM_ROWS];
  logic [kpd_pkg::ROW_W-1:0]     row_r;
  logic [kpd_pkg::ROW_W-1:0]     row_nxt;

  logic                          s1_valid_r;
  logic [kpd_pkg::CMD_W-1:0]     s1_cmd_r;
  logic [kpd_pkg::KEY_W-1:0]     s1_raw_r;
  logic [kpd_pkg::KEY_W-1:0]     s1_mask_r;

  logic                          out_valid_r;
  logic [kpd_pkg::KEY_W-1:0]     out_bits_r;
  logic [kpd_pkg::ROW_W-1:0]     out_row_r;

  logic                          s1_go;
  logic                          s1_fire;
  logic                          in_fire;
  kpd_pkg::row_state_t           row_cur;
  kpd_pkg::row_state_t           row_new;
  logic [kpd_pkg::KEY_W-1:0]     bits_new;
  logic                          scan_new;

  assign s1_go    = ~out_valid_r | ~out_stall;
  assign s1_fire  = s1_valid_r & s1_go;
  assign in_stall = s1_valid_r & ~s1_go;
  assign in_fire  = in_valid & ~in_stall;
  assign row_cur  = rows_r[row_r];

  kpd_row_update u_row (
    .cmd        (s1_cmd_r),
    .raw_keys   (s1_raw_r),
    .query_mask (s1_mask_r),
    .cfg        (cfg_r),
    .cur        (row_cur),
    .nxt        (row_new),
    .key_bits   (bits_new),
    .is_scan    (scan_new)
  );

  always_comb begin
    row_nxt = row_r;
    if (s1_fire && scan_new) begin
      if (row_r == kpd_pkg::ROW_W'(kpd_pkg::NUM_ROWS - 1)) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_keys <= kpd_pkg::RST_REPEAT_KEYS;
      cfg_r.first_delay <= kpd_pkg::RST_FIRST_DELAY;
      cfg_r.repeat_per  <= kpd_pkg::RST_REPEAT_PER;
    end else if (cfg_we) begin
      case (kpd_pkg::cfg_idx_t'(cfg_index))
        kpd_pkg::CFG_REPEAT_KEYS: cfg_r.repeat_keys <= cfg_wdata;
        kpd_pkg::CFG_FIRST_DELAY: cfg_r.first_delay <= cfg_wdata;
        kpd_pkg::CFG_REPEAT_PER:  cfg_r.repeat_per  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kpd_pkg::NUM_ROWS; i++) begin
        rows_r[i] <= '0;
      end
      row_r <= '0;
    end else begin
      if (s1_fire) begin
        rows_r[row_r] <= row_new;
      end
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_cmd;
      s1_raw_r  <= in_raw_keys;
      s1_mask_r <= in_query_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_bits_r <= bits_new;
      out_row_r  <= row_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_bits = out_bits_r;
  assign out_row_used = kpd_pkg::ROW_USED_W'(out_row_r);

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= kpd_pkg::ROW_W'(kpd_pkg::NUM_ROWS - 1))
    else $error("row index out of range");

  a_query_keeps_row: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !scan_new |=> $stable(row_r))
    else $error("query moved the row index");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r && out_row_r == $past(row_r))
    else $error("result word lost or wrong row");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipe");

endmodule
`default_nettype wire
